[rtl/core/srq_pkg.sv]
// srq_pkg: shared types and constants for the slotted ring queue.
// Holds the item structs, opcode and status codes, and the control/status
// structs between controller and datapath. No dependencies.
package srq_pkg;

	// default geometry
	localparam int SLOTS_DEF        = 8;
	localparam int SLOT_ENTRIES_DEF = 32;

	// opcodes
	localparam logic [2:0] OP_PUSH    = 3'd0;
	localparam logic [2:0] OP_POP     = 3'd1;
	localparam logic [2:0] OP_RD_HEAD = 3'd2;
	localparam logic [2:0] OP_RD_TAIL = 3'd3;
	localparam logic [2:0] OP_CLEAR   = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_BEYOND = 2'd3;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] data_value;
		logic               last_word;
		logic [4:0]         word_index;
		logic [2:0]         slot_select;
	} srq_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_data;
		logic               queue_empty;
		logic               queue_full;
		logic [3:0]         occupancy;
	} srq_out_t;

	// controller -> datapath
	typedef struct packed {
		logic sweep;      // reset clearing pass, one entry a cycle
		logic capture;    // take the input item
		logic exec;       // run the captured item
		logic rd_take;    // latch word read data into the result
		logic scan_load;  // start scanning a slot for clear
		logic scan_step;  // test one word, fetch the next
		logic out_load;   // load the output register
	} srq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic sweep_last;
		logic rd_issued;
		logic len_issued;
		logic scan_none;
		logic scan_last;
		logic out_free;
	} srq_sts_t;

endpackage

[rtl/core/srq_ram.sv]
// srq_ram: generic single write port, single read port RAM with registered
// read data. No dependencies.
module srq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/srq_ctrl.sv]
// srq_ctrl: sequencing state machine of the slotted ring queue.
// Depends on srq_pkg for the command and status structs.
module srq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  srq_pkg::srq_sts_t sts,
	output srq_pkg::srq_cmd_t cmd
);

	import srq_pkg::*;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_EXEC,
		S_RDWAIT,
		S_LENWAIT,
		S_SCAN,
		S_DONE
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	// commands decoded from the current state
	always_comb begin
		cmd           = '0;
		cmd.sweep     = (state_q == S_SWEEP);
		cmd.capture   = (state_q == S_IDLE) && in_valid;
		cmd.exec      = (state_q == S_EXEC);
		cmd.rd_take   = (state_q == S_RDWAIT);
		cmd.scan_load = (state_q == S_LENWAIT) && !sts.scan_none;
		cmd.scan_step = (state_q == S_SCAN);
		cmd.out_load  = (state_q == S_DONE) && sts.out_free;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			case (state_q)
				S_SWEEP: begin
					if (sts.sweep_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (sts.rd_issued)       state_q <= S_RDWAIT;
					else if (sts.len_issued) state_q <= S_LENWAIT;
					else                     state_q <= S_DONE;
				end
				S_RDWAIT: begin
					state_q <= S_DONE;
				end
				S_LENWAIT: begin
					if (sts.scan_none) state_q <= S_DONE;
					else               state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (sts.scan_last) state_q <= S_DONE;
				end
				S_DONE: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/srq_datapath.sv]
// srq_datapath: ring pointers, word and length stores, clear scanner and
// output register of the slotted ring queue.
// Depends on srq_pkg and srq_ram.
module srq_datapath #(
	parameter int SLOTS        = 8,
	parameter int SLOT_ENTRIES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  srq_pkg::srq_in_t  in_item,
	input  srq_pkg::srq_cmd_t cmd,
	output srq_pkg::srq_sts_t sts,
	input  logic              out_ready,
	output logic              out_valid,
	output srq_pkg::srq_out_t out_item
);

	import srq_pkg::*;

	localparam int DEPTH = SLOTS * SLOT_ENTRIES;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = $clog2(SLOTS);
	localparam int UW    = $clog2(SLOTS + 1);
	localparam int LW    = $clog2(SLOT_ENTRIES + 1);

	// word address of entry i of slot s
	function automatic logic [AW-1:0] word_addr(input logic [SW-1:0] s,
	                                            input logic [LW-1:0] i);
		word_addr = AW'(int'(s) * SLOT_ENTRIES + int'(i));
	endfunction

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
		next_slot = (s == SW'(SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

	srq_in_t         req_q;
	logic [SW-1:0]   head_q, tail_q;
	logic [UW-1:0]   used_q;
	logic [LW-1:0]   wip_q;
	logic            rej_q;
	logic [AW-1:0]   sweep_q;
	logic [LW-1:0]   scan_idx_q, scan_len_q;
	logic [1:0]      res_status_q;
	logic [31:0]     res_data_q;
	logic            out_valid_q;
	srq_out_t        out_q;

	logic            full, empty, idx_beyond, clr_ok, push_rej, room;
	logic            push_wr, commit, rd_issue, len_issue, match;
	logic [LW-1:0]   wip_inc, len_new, scan_next;
	logic [SW-1:0]   rd_slot, sel_slot;
	logic [1:0]      st_d;

	logic            w_we, w_re;
	logic [AW-1:0]   w_waddr, w_raddr;
	logic [31:0]     w_wdata, w_rdata;
	logic            l_we;
	logic [SW-1:0]   l_waddr;
	logic [LW-1:0]   l_wdata, l_rdata;

	// item decode
	assign full       = (used_q == UW'(SLOTS));
	assign empty      = (used_q == '0);
	assign idx_beyond = (32'(req_q.word_index) >= 32'(SLOT_ENTRIES));
	assign clr_ok     = (32'(req_q.slot_select) < 32'(SLOTS));
	assign push_rej   = rej_q || ((wip_q == '0) && full);
	assign room       = (32'(wip_q) < 32'(SLOT_ENTRIES));
	assign wip_inc    = wip_q + 1'b1;
	assign len_new    = room ? wip_inc : wip_q;
	assign rd_slot    = (req_q.opcode == OP_RD_HEAD) ? head_q : tail_q;
	assign sel_slot   = SW'(req_q.slot_select);
	assign scan_next  = scan_idx_q + 1'b1;

	assign push_wr   = cmd.exec && (req_q.opcode == OP_PUSH) && !push_rej && room;
	assign commit    = cmd.exec && (req_q.opcode == OP_PUSH) && !push_rej &&
	                   req_q.last_word;
	assign rd_issue  = cmd.exec && !idx_beyond &&
	                   (((req_q.opcode == OP_RD_HEAD) && !empty) ||
	                    ((req_q.opcode == OP_RD_TAIL) && !full));
	assign len_issue = cmd.exec && (req_q.opcode == OP_CLEAR) && clr_ok;
	assign match     = (w_rdata == 32'(req_q.data_value));

	// result status of the item
	always_comb begin
		case (req_q.opcode)
			OP_PUSH:    st_d = push_rej ? ST_FULL : (room ? ST_OK : ST_BEYOND);
			OP_POP:     st_d = empty ? ST_EMPTY : ST_OK;
			OP_RD_HEAD: st_d = empty ? ST_EMPTY : (idx_beyond ? ST_BEYOND : ST_OK);
			OP_RD_TAIL: st_d = full ? ST_FULL : (idx_beyond ? ST_BEYOND : ST_OK);
			default:    st_d = ST_OK;
		endcase
	end

	// word store ports
	always_comb begin
		w_we    = cmd.sweep || push_wr || (cmd.scan_step && match);
		w_wdata = push_wr ? 32'(req_q.data_value) : '0;
		if (cmd.sweep)    w_waddr = sweep_q;
		else if (push_wr) w_waddr = word_addr(tail_q, wip_q);
		else              w_waddr = word_addr(sel_slot, scan_idx_q);
		w_re = rd_issue || cmd.scan_load || (cmd.scan_step && !sts.scan_last);
		if (rd_issue)            w_raddr = word_addr(rd_slot, LW'(req_q.word_index));
		else if (cmd.scan_load)  w_raddr = word_addr(sel_slot, '0);
		else                     w_raddr = word_addr(sel_slot, scan_next);
	end

	// length store ports
	always_comb begin
		l_we    = (cmd.sweep && ({1'b0, sweep_q} < (AW + 1)'(SLOTS))) || commit;
		l_waddr = cmd.sweep ? SW'(sweep_q) : tail_q;
		l_wdata = cmd.sweep ? '0 : len_new;
	end

	srq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_word_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.re    (w_re),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	srq_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_len_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.re    (len_issue),
		.raddr (sel_slot),
		.rdata (l_rdata)
	);

	// status towards the controller
	always_comb begin
		sts            = '0;
		sts.sweep_last = (sweep_q == AW'(DEPTH - 1));
		sts.rd_issued  = rd_issue;
		sts.len_issued = len_issue;
		sts.scan_none  = (l_rdata == '0);
		sts.scan_last  = (scan_next == scan_len_q);
		sts.out_free   = !out_valid_q || out_ready;
	end

	// ring control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			used_q  <= '0;
			wip_q   <= '0;
			rej_q   <= 1'b0;
			sweep_q <= '0;
		end else begin
			if (cmd.sweep) sweep_q <= sweep_q + 1'b1;
			if (cmd.exec && (req_q.opcode == OP_PUSH)) begin
				if (push_rej) begin
					rej_q <= !req_q.last_word;
				end else if (req_q.last_word) begin
					tail_q <= next_slot(tail_q);
					used_q <= used_q + 1'b1;
					wip_q  <= '0;
				end else if (room) begin
					wip_q <= wip_inc;
				end
			end
			if (cmd.exec && (req_q.opcode == OP_POP) && !empty) begin
				head_q <= next_slot(head_q);
				used_q <= used_q - 1'b1;
			end
		end
	end

	// item, scanner and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= in_item;
		if (cmd.exec) begin
			res_status_q <= st_d;
			res_data_q   <= '0;
		end
		if (cmd.rd_take) res_data_q <= w_rdata;
		if (cmd.scan_load) begin
			scan_len_q <= l_rdata;
			scan_idx_q <= '0;
		end
		if (cmd.scan_step) scan_idx_q <= scan_next;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.status      <= res_status_q;
			out_q.read_data   <= signed'(res_data_q);
			out_q.queue_empty <= empty;
			out_q.queue_full  <= full;
			out_q.occupancy   <= 4'(used_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[rtl/core/slotted_ring_queue.sv]
// Slotted ring queue: ring of SLOTS lists of up to SLOT_ENTRIES words each.
// Each item passes S_EXEC and then S_DONE, where its result is loaded; issued reads go through S_RDWAIT
// between them, clears of a slot in range through S_LENWAIT and, if the slot holds words, S_SCAN.
// One item at a time: the next item is taken the cycle after the result is loaded, and a new
// result waits in S_DONE while a held earlier result waits for out_ready.
// After reset a clearing pass zeroes the stores. Needs srq_pkg, srq_ctrl and srq_datapath.
module slotted_ring_queue #(
	parameter int SLOTS        = srq_pkg::SLOTS_DEF,
	parameter int SLOT_ENTRIES = srq_pkg::SLOT_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  srq_pkg::srq_in_t  in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output srq_pkg::srq_out_t out_item
);

	import srq_pkg::*;

	srq_cmd_t cmd;
	srq_sts_t sts;

	// sequencer
	srq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// stores, pointers and output register
	srq_datapath #(
		.SLOTS        (SLOTS),
		.SLOT_ENTRIES (SLOT_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

endmodule

[sim/slotted_ring_queue_tb.sv]
// Self-checking testbench for slotted_ring_queue: directed and random item streams
// checked against a behavioural ring model kept in this file.
// Depends on srq_pkg and the slotted_ring_queue RTL.
module slotted_ring_queue_tb;
	import srq_pkg::*;

	localparam int N_SLOTS     = SLOTS_DEF;
	localparam int N_ENT       = SLOT_ENTRIES_DEF;
	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 60;
	localparam int RANDOM_ITEMS = 1150;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	srq_in_t  in_item;
	logic     out_valid;
	logic     out_ready;
	srq_out_t out_item;

	// ring model state
	logic [31:0] ring_words [N_SLOTS*N_ENT];
	int unsigned ring_len [N_SLOTS];
	int unsigned ring_head;
	int unsigned ring_tail;
	int unsigned ring_used;
	int unsigned open_words;
	logic        open_rejected;

	srq_out_t pending_results [$];
	srq_out_t oldest;
	int       mismatches;
	int       items_sent;
	bit       no_gaps;
	bit       hold_request;

	slotted_ring_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// advance the ring model by one item and give the answer it produces
	function automatic srq_out_t ring_step(srq_in_t it);
		srq_out_t    res;
		logic        full;
		logic        empty;
		int unsigned len;
		int unsigned base;
		res = '0;
		res.status = ST_OK;
		full = (ring_used >= N_SLOTS);
		empty = (ring_used == 0);
		case (it.opcode)
			OP_PUSH: begin
				if (open_rejected || (open_words == 0 && full)) begin
					res.status = ST_FULL;
					open_rejected = !it.last_word;
				end else begin
					if (open_words < N_ENT) begin
						ring_words[ring_tail*N_ENT + open_words] = it.data_value;
						open_words++;
					end else begin
						res.status = ST_BEYOND;
					end
					if (it.last_word) begin
						ring_len[ring_tail] = open_words;
						ring_tail = (ring_tail + 1 >= N_SLOTS) ? 0 : ring_tail + 1;
						ring_used++;
						open_words = 0;
					end
				end
			end
			OP_POP: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					ring_head = (ring_head + 1 >= N_SLOTS) ? 0 : ring_head + 1;
					ring_used--;
				end
			end
			OP_RD_HEAD: begin
				if (empty)
					res.status = ST_EMPTY;
				else if (it.word_index >= N_ENT)
					res.status = ST_BEYOND;
				else
					res.read_data = ring_words[ring_head*N_ENT + it.word_index];
			end
			OP_RD_TAIL: begin
				if (full)
					res.status = ST_FULL;
				else if (it.word_index >= N_ENT)
					res.status = ST_BEYOND;
				else
					res.read_data = ring_words[ring_tail*N_ENT + it.word_index];
			end
			OP_CLEAR: begin
				if (it.slot_select < N_SLOTS) begin
					len = ring_len[it.slot_select];
					if (len > N_ENT)
						len = N_ENT;
					base = it.slot_select * N_ENT;
					for (int i = 0; i < len; i++)
						if (ring_words[base + i] == it.data_value)
							ring_words[base + i] = '0;
				end
			end
			default: begin
				// opcodes above clear are no-ops
			end
		endcase
		res.queue_empty = (ring_used == 0);
		res.queue_full = (ring_used >= N_SLOTS);
		res.occupancy = ring_used[3:0];
		return res;
	endfunction

	// idle length for either side: mostly short, a few long
	function automatic int rand_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// words from a small pool so that clears find matches, plus extremes and random words
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4, 5: return $urandom_range(1, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic srq_in_t random_item();
		srq_in_t it;
		it.opcode = 3'($urandom_range(0, 7));
		it.data_value = $urandom;
		it.last_word = 1'($urandom_range(0, 1));
		it.word_index = 5'($urandom_range(0, 31));
		it.slot_select = 3'($urandom_range(0, 7));
		return it;
	endfunction

	function automatic srq_in_t make_item(logic [2:0] op, logic [31:0] value, logic last,
			logic [4:0] idx, logic [2:0] sel);
		srq_in_t it;
		it.opcode = op;
		it.data_value = value;
		it.last_word = last;
		it.word_index = idx;
		it.slot_select = sel;
		return it;
	endfunction

	// offer one item, hold it until taken, then record its answer
	task automatic send_item(input srq_in_t it);
		int gap;
		gap = rand_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(ring_step(it));
		if (it.opcode <= OP_CLEAR)
			items_sent++;
	endtask

	task automatic send_list(input int len);
		srq_in_t it;
		for (int i = 0; i < len; i++) begin
			it = random_item();
			it.opcode = OP_PUSH;
			it.data_value = pick_value();
			it.last_word = (i == len - 1);
			send_item(it);
		end
	endtask

	// stop offering and let every outstanding answer come back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// empty ring: pops and head reads rejected, tail reads, clears and unknown opcodes harmless
	task automatic test_empty_ring();
		send_item(make_item(OP_POP, '0, 1'b0, 5'd0, 3'd0));
		send_item(make_item(OP_RD_HEAD, '0, 1'b0, 5'd0, 3'd0));
		send_item(make_item(OP_RD_TAIL, '0, 1'b0, 5'd31, 3'd0));
		send_item(make_item(OP_CLEAR, '0, 1'b0, 5'd0, 3'd0));
		send_item(make_item(OP_CLEAR, 32'hFFFF_FFFF, 1'b1, 5'd31, 3'd7));
		for (int op = OP_CLEAR + 1; op < 8; op++)
			send_item(make_item(3'(op), $urandom, 1'b1, 5'd31, 3'd7));
	endtask

	// one short list: tail reads mid-list, head reads at the last word and past length, clear of a word
	task automatic test_short_list();
		send_item(make_item(OP_PUSH, 32'h8000_0000, 1'b0, 5'd0, 3'd0));
		send_item(make_item(OP_RD_TAIL, '0, 1'b0, 5'd0, 3'd0));
		send_item(make_item(OP_PUSH, 32'h7FFF_FFFF, 1'b0, 5'd0, 3'd0));
		send_item(make_item(OP_RD_TAIL, '0, 1'b0, 5'd1, 3'd0));
		send_item(make_item(OP_PUSH, 32'hFFFF_FFFF, 1'b1, 5'd0, 3'd0));
		send_item(make_item(OP_RD_HEAD, '0, 1'b0, 5'd2, 3'd0));
		send_item(make_item(OP_RD_HEAD, '0, 1'b0, 5'd31, 3'd0));
		send_item(make_item(OP_CLEAR, 32'h7FFF_FFFF, 1'b0, 5'd0, 3'd0));
		send_item(make_item(OP_RD_HEAD, '0, 1'b0, 5'd1, 3'd0));
		send_item(make_item(OP_CLEAR, 32'hFFFF_FFFF, 1'b0, 5'd0, 3'd5));
	endtask

	// fill to full, reject a list across a pop, refill, then empty it all
	task automatic test_full_ring();
		for (int i = 1; i < N_SLOTS; i++)
			send_list(1);
		send_item(make_item(OP_RD_TAIL, '0, 1'b0, 5'd0, 3'd0));
		send_item(make_item(OP_PUSH, 32'h1234_5678, 1'b0, 5'd0, 3'd0));
		send_item(make_item(OP_POP, '0, 1'b0, 5'd0, 3'd0));
		send_item(make_item(OP_PUSH, 32'h0000_0001, 1'b0, 5'd0, 3'd0));
		send_item(make_item(OP_PUSH, 32'h0000_0002, 1'b1, 5'd0, 3'd0));
		send_item(make_item(OP_RD_TAIL, '0, 1'b0, 5'd3, 3'd0));
		send_list(1);
		send_item(make_item(OP_RD_HEAD, '0, 1'b0, 5'd0, 3'd0));
		send_item(make_item(OP_CLEAR, 32'h0000_0001, 1'b0, 5'd0, ring_head[2:0]));
		for (int i = 0; i <= N_SLOTS; i++)
			send_item(make_item(OP_POP, '0, 1'b0, 5'd0, 3'd0));
		// slot no longer in use still cleared over its old length
		send_item(make_item(OP_CLEAR, 32'hFFFF_FFFF, 1'b0, 5'd0, 3'd0));
	endtask

	// list longer than a slot: extra words dropped, slot commits full length
	task automatic test_overlong_list();
		for (int i = 0; i < N_ENT + 2; i++)
			send_item(make_item(OP_PUSH, i, i == N_ENT + 1, 5'd0, 3'd0));
		send_item(make_item(OP_RD_HEAD, '0, 1'b0, 5'd31, 3'd0));
		send_item(make_item(OP_CLEAR, 32'd5, 1'b0, 5'd0, ring_head[2:0]));
		send_item(make_item(OP_RD_HEAD, '0, 1'b0, 5'd5, 3'd0));
		send_item(make_item(OP_POP, '0, 1'b0, 5'd0, 3'd0));
	endtask

	// results held back for a long stretch while items keep coming
	task automatic test_backpressure();
		srq_in_t it;
		hold_request = 1'b1;
		no_gaps = 1'b1;
		for (int i = 0; i < 20; i++) begin
			it = random_item();
			it.opcode = 3'($urandom_range(OP_PUSH, OP_CLEAR));
			send_item(it);
		end
		no_gaps = 1'b0;
	endtask

	// mostly well-formed lists with random reads, pops and clears; some noise
	task automatic test_random_traffic();
		srq_in_t it;
		int      start;
		int      r;
		int      len;
		int      push_pct;
		int      phase;
		start = items_sent;
		phase = 0;
		push_pct = 60;
		while (items_sent - start < RANDOM_ITEMS) begin
			// alternate filling and draining phases, with some gap-free stretches
			if ((items_sent - start) / 100 != phase) begin
				phase = (items_sent - start) / 100;
				push_pct = (phase % 2 == 0) ? 60 : 25;
				no_gaps = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < push_pct) begin
				r = $urandom_range(0, 99);
				if (r < 80)
					len = $urandom_range(1, 6);
				else if (r < 95)
					len = $urandom_range(7, N_ENT - 1);
				else
					len = $urandom_range(N_ENT, N_ENT + 3);
				send_list(len);
			end else begin
				it = random_item();
				r = $urandom_range(0, 99);
				if (r < 30)
					it.opcode = OP_POP;
				else if (r < 50)
					it.opcode = OP_RD_HEAD;
				else if (r < 70)
					it.opcode = OP_RD_TAIL;
				else if (r < 85) begin
					it.opcode = OP_CLEAR;
					it.data_value = pick_value();
				end
				send_item(it);
			end
		end
		no_gaps = 1'b0;
	endtask

	// result sink: random ready, with a long hold when asked
	initial begin : result_sink
		int n;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				n = rand_gap();
				if (n == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					repeat (n - 1) @(posedge clk);
				end
			end
		end
	end

	// result checker against the oldest predicted answer
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("tb: unexpected result %p", out_item);
				mismatches++;
			end else begin
				oldest = pending_results.pop_front();
				if (out_item.status !== oldest.status ||
						out_item.read_data !== oldest.read_data ||
						out_item.queue_empty !== oldest.queue_empty ||
						out_item.queue_full !== oldest.queue_full ||
						out_item.occupancy !== oldest.occupancy) begin
					if (mismatches < 10)
						$display("tb: mismatch exp %p got %p", oldest, out_item);
					mismatches++;
				end
			end
		end
	end

	// watchdog: too long with no item moving on either side
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : main
		mismatches = 0;
		items_sent = 0;
		no_gaps = 1'b0;
		hold_request = 1'b0;
		for (int i = 0; i < N_SLOTS*N_ENT; i++)
			ring_words[i] = '0;
		for (int i = 0; i < N_SLOTS; i++)
			ring_len[i] = 0;
		ring_head = 0;
		ring_tail = 0;
		ring_used = 0;
		open_words = 0;
		open_rejected = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_ring();
		test_short_list();
		test_full_ring();
		wait_for_results();
		test_overlong_list();
		test_backpressure();
		wait_for_results();
		test_random_traffic();
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

[sim.f]
rtl/core/srq_pkg.sv
rtl/core/srq_ram.sv
rtl/core/srq_ctrl.sv
rtl/core/srq_datapath.sv
rtl/core/slotted_ring_queue.sv
sim/slotted_ring_queue_tb.sv
